>>> rtl/swing_step_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// swing_step_sequencer_core_defines.svh
// Assertion macros shared by the checkers of the step sequencer.
// ----------------------------------------------------------------------------
`ifndef SWING_STEP_SEQUENCER_CORE_DEFINES_SVH
`define SWING_STEP_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Opcodes, register indexes, fixed field widths and shared types of the
// swing step sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

	// input opcodes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TOGGLE = 2'd1;
	localparam logic [1:0] OP_STEP   = 2'd2;
	localparam logic [1:0] OP_LENGTH = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TEMPO   = 2'd0;
	localparam logic [1:0] CFG_SWING   = 2'd1;
	localparam logic [1:0] CFG_CHANNEL = 2'd2;
	localparam logic [1:0] CFG_PATTERN = 2'd3;

	// field widths
	localparam int BPM_W      = 8;
	localparam int SWING_W    = 7;
	localparam int CHAN_W     = 4;
	localparam int SLOT_W     = 3;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int LEN_IN_W   = 4;
	localparam int STATUS_W   = 8;
	localparam int STEP_NOW_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// timing arithmetic
	localparam int QW          = 16;               // 60000 / bpm quotient
	localparam int HALF_W      = QW - 1;           // step time, even steps
	localparam int REL_W       = QW - 2;           // gate time
	localparam int MS_W        = 16;               // elapsed ms counter
	localparam int PROD_W      = HALF_W + SWING_W; // half * swing
	localparam int RECIP_W     = 22;
	localparam int RECIP_SHIFT = 27;
	localparam int SCALED_W    = PROD_W + RECIP_W;
	localparam int SWUNG_W     = SCALED_W - RECIP_SHIFT;

	localparam logic [QW-1:0]       MINUTE_MS = 16'd60000;
	// ceil(2^27 / 50): floor(x / 50) exact for every x below 2^22
	localparam logic [RECIP_W-1:0]  RECIP_50  = 22'd2684355;
	localparam logic [MS_W-1:0]     MS_MAX    = 16'hFFFF;
	localparam logic [BPM_W-1:0]    BPM_RESET   = 8'd120;
	localparam logic [SWING_W-1:0]  SWING_RESET = 7'd50;

	localparam logic [STATUS_W-1:0] STATUS_OFF  = 8'h80;
	localparam logic [STATUS_W-1:0] STATUS_ON   = 8'h90;
	localparam int                  NOTE_BASE   = 60;
	localparam logic [VEL_W-1:0]    VEL_DEFAULT = 7'd100;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/swing_step_sequencer_core.sv
// ----------------------------------------------------------------------------
// swing_step_sequencer_core
// Step sequencer with swing: plays a pattern from a bank held in a step
// memory, paced by one-millisecond ticks, and emits MIDI note messages.
//
//   channel  direction  handshake            beat
//   in       in         in_valid/in_ready    op and step/length write fields
//   out      out        out_valid/out_ready  one note message
//   cfg      in         cfg_valid/cfg_ready  register index and data
//
// A tick runs the restoring divider, which works out 60000/tempo one bit
// per cycle; a tick while playing then takes two multiply stages for swing,
// and a step that is reached is read from the step memory in ST_PLAY1/2.
// After reset a clearing pass writes every step memory entry with the
// default scale; no item is taken meanwhile, cfg writes are.
// A tick or stop holds in its last cycle until the output buffer is empty;
// the next item is accepted while results of the previous one wait.
// ----------------------------------------------------------------------------
module swing_step_sequencer_core #(
	parameter int STEP_COUNT    = 8,
	parameter int PATTERN_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic [sss_pkg::SLOT_W-1:0]        pattern_slot,
	input  logic [sss_pkg::SLOT_W-1:0]        step_slot,
	input  logic [sss_pkg::NOTE_W-1:0]        note_value,
	input  logic [sss_pkg::VEL_W-1:0]         velocity_value,
	input  logic                              gate_on,
	input  logic [sss_pkg::LEN_IN_W-1:0]      length_value,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sss_pkg::STATUS_W-1:0]      status_byte,
	output logic [sss_pkg::NOTE_W-1:0]        note_number,
	output logic [sss_pkg::VEL_W-1:0]         velocity_out,
	output logic [sss_pkg::STEP_NOW_W-1:0]    step_now,
	output logic                              last_of_run,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sss_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SPW   = $clog2(STEP_COUNT);
	localparam int LW    = $clog2(STEP_COUNT + 1);
	localparam int PW    = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
	localparam int DEPTH = PATTERN_COUNT * STEP_COUNT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_MUL1  = 4'd3;
	localparam logic [3:0] ST_MUL2  = 4'd4;
	localparam logic [3:0] ST_STEP  = 4'd5;
	localparam logic [3:0] ST_PLAY1 = 4'd6;
	localparam logic [3:0] ST_PLAY2 = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	typedef struct packed {
		logic                       gate;
		logic [sss_pkg::VEL_W-1:0]  vel;
		logic [sss_pkg::NOTE_W-1:0] note;
	} step_entry_t;

	function automatic logic [PW-1:0] pattern_of(input logic [2:0] sel);
		logic [2:0] r;
		r = sel;
		if (PATTERN_COUNT < 8) begin
			for (int i = 0; i < 7; i++) begin
				if (r >= 3'(PATTERN_COUNT))
					r = r - 3'(PATTERN_COUNT);
			end
		end
		return PW'(r);
	endfunction

	function automatic logic [AW-1:0] mem_addr(input logic [PW-1:0] pat,
	                                           input logic [SPW-1:0] stp);
		return AW'(pat) * AW'(STEP_COUNT) + AW'(stp);
	endfunction

	function automatic logic [LW-1:0] clamp_len(input logic [sss_pkg::LEN_IN_W-1:0] v);
		if (v == '0)
			return LW'(1);
		else if (int'(v) > STEP_COUNT)
			return LW'(STEP_COUNT);
		else
			return LW'(v);
	endfunction

	// control and configuration
	logic [3:0]                    state_q;
	logic [PW-1:0]                 clr_pat_q;
	logic [SPW-1:0]                clr_step_q;
	logic [sss_pkg::BPM_W-1:0]     tempo_q;
	logic [sss_pkg::SWING_W-1:0]   swing_q;
	logic [sss_pkg::CHAN_W-1:0]    chan_q;
	logic [2:0]                    psel_q;

	// play state
	logic                          playing_q;
	logic                          start_wait_q;
	logic [SPW-1:0]                pos_q;
	logic [sss_pkg::MS_W-1:0]      mss_q;
	logic                          snd_v_q;
	logic [sss_pkg::NOTE_W-1:0]    snd_note_q;
	logic                          rel_pend_q;
	logic [sss_pkg::REL_W-1:0]     rel_q;

	// per-item work and arithmetic
	logic                          wk_off_v_q;
	logic [sss_pkg::NOTE_W-1:0]    wk_off_note_q;
	logic                          wk_on_v_q;
	logic [sss_pkg::NOTE_W-1:0]    wk_on_note_q;
	logic [sss_pkg::VEL_W-1:0]     wk_on_vel_q;
	logic [sss_pkg::PROD_W-1:0]    prod_q;
	logic [sss_pkg::SCALED_W-1:0]  scaled_q;

	// output buffer
	logic                          ob_off_v_q;
	logic                          ob_on_v_q;
	logic [sss_pkg::STATUS_W-1:0]  ob_off_status_q;
	logic [sss_pkg::STATUS_W-1:0]  ob_on_status_q;
	logic [sss_pkg::NOTE_W-1:0]    ob_off_note_q;
	logic [sss_pkg::NOTE_W-1:0]    ob_on_note_q;
	logic [sss_pkg::VEL_W-1:0]     ob_on_vel_q;
	logic [sss_pkg::STEP_NOW_W-1:0] ob_step_q;

	// memories
	step_entry_t                   step_mem [DEPTH];
	logic [LW-1:0]                 len_mem  [PATTERN_COUNT];
	step_entry_t                   step_rd_q;
	logic [LW-1:0]                 len_rd_q;

	logic                          sm_we;
	logic [AW-1:0]                 sm_wa;
	step_entry_t                   sm_wd;
	logic [AW-1:0]                 sm_ra;
	logic                          lm_we;
	logic [PW-1:0]                 lm_wa;
	logic [LW-1:0]                 lm_wd;

	logic                          in_fire;
	logic                          out_fire;
	logic                          clearing;
	logic                          clr_last;
	logic                          slot_ok;
	logic                          step_ok;
	logic [PW-1:0]                 cur_pat;
	logic [sss_pkg::BPM_W-1:0]     eff_bpm;

	logic                          div_start;
	logic [sss_pkg::QW-1:0]        quotient;
	sss_pkg::div_stat_t            div_stat;

	logic [sss_pkg::HALF_W-1:0]    half_ms;
	logic [sss_pkg::SWUNG_W-1:0]   swung;
	logic [sss_pkg::MS_W-1:0]      dur;
	logic [sss_pkg::MS_W-1:0]      mss_inc;
	logic [LW-1:0]                 pos_inc;
	logic [SPW-1:0]                pos_wrap;
	logic [sss_pkg::REL_W-1:0]     rel_dec;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign clearing  = (state_q == ST_CLEAR);
	assign clr_last  = (int'(clr_pat_q) == PATTERN_COUNT - 1)
	                 && (int'(clr_step_q) == STEP_COUNT - 1);
	assign slot_ok   = (int'(pattern_slot) < PATTERN_COUNT);
	assign step_ok   = slot_ok && (int'(step_slot) < STEP_COUNT);
	assign cur_pat   = pattern_of(psel_q);
	assign eff_bpm   = (tempo_q == '0) ? sss_pkg::BPM_W'(1) : tempo_q;
	assign div_start = in_fire && (op == sss_pkg::OP_TICK);

	sss_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sss_pkg::MINUTE_MS),
		.divisor  (eff_bpm),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_comb begin
		half_ms = quotient[sss_pkg::QW-1:1];
		swung   = scaled_q[sss_pkg::SCALED_W-1:sss_pkg::RECIP_SHIFT];
		if (pos_q[0]) begin
			// odd step: swing-scaled, saturated to the counter range
			if (swung > sss_pkg::SWUNG_W'(sss_pkg::MS_MAX))
				dur = sss_pkg::MS_MAX;
			else
				dur = swung[sss_pkg::MS_W-1:0];
		end else begin
			dur = {1'b0, half_ms};
		end
		mss_inc  = (mss_q != sss_pkg::MS_MAX) ? (mss_q + 1'b1) : mss_q;
		pos_inc  = LW'(pos_q) + 1'b1;
		pos_wrap = (pos_inc >= len_rd_q) ? '0 : SPW'(pos_inc);
		rel_dec  = (rel_q != '0) ? (rel_q - 1'b1) : '0;
	end

	// memory ports
	always_comb begin
		if (clearing) begin
			sm_we      = 1'b1;
			sm_wa      = mem_addr(clr_pat_q, clr_step_q);
			sm_wd.gate = 1'b1;
			sm_wd.vel  = sss_pkg::VEL_DEFAULT;
			sm_wd.note = sss_pkg::NOTE_W'(sss_pkg::NOTE_BASE + int'(clr_step_q));
			lm_we      = (clr_step_q == '0);
			lm_wa      = clr_pat_q;
			lm_wd      = LW'(STEP_COUNT);
		end else begin
			sm_we      = in_fire && (op == sss_pkg::OP_STEP) && step_ok;
			sm_wa      = mem_addr(PW'(pattern_slot), SPW'(step_slot));
			sm_wd.gate = gate_on;
			sm_wd.vel  = velocity_value;
			sm_wd.note = note_value;
			lm_we      = in_fire && (op == sss_pkg::OP_LENGTH) && slot_ok;
			lm_wa      = PW'(pattern_slot);
			lm_wd      = clamp_len(length_value);
		end
		sm_ra = mem_addr(cur_pat, pos_q);
	end

	always_ff @(posedge clk) begin
		if (sm_we)
			step_mem[sm_wa] <= sm_wd;
		step_rd_q <= step_mem[sm_ra];
	end

	always_ff @(posedge clk) begin
		if (lm_we)
			len_mem[lm_wa] <= lm_wd;
		len_rd_q <= len_mem[cur_pat];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= sss_pkg::BPM_RESET;
			swing_q <= sss_pkg::SWING_RESET;
			chan_q  <= '0;
			psel_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sss_pkg::CFG_TEMPO:   tempo_q <= cfg_data;
				sss_pkg::CFG_SWING:   swing_q <= cfg_data[sss_pkg::SWING_W-1:0];
				sss_pkg::CFG_CHANNEL: chan_q  <= cfg_data[sss_pkg::CHAN_W-1:0];
				sss_pkg::CFG_PATTERN: psel_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_pat_q    <= '0;
			clr_step_q   <= '0;
			playing_q    <= 1'b0;
			start_wait_q <= 1'b0;
			pos_q        <= '0;
			mss_q        <= '0;
			snd_v_q      <= 1'b0;
			rel_pend_q   <= 1'b0;
			rel_q        <= '0;
			wk_off_v_q   <= 1'b0;
			wk_on_v_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_last) begin
						state_q <= ST_IDLE;
					end else if (int'(clr_step_q) == STEP_COUNT - 1) begin
						clr_step_q <= '0;
						clr_pat_q  <= clr_pat_q + 1'b1;
					end else begin
						clr_step_q <= clr_step_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						wk_off_v_q <= 1'b0;
						wk_on_v_q  <= 1'b0;
						case (op)
							sss_pkg::OP_TICK: begin
								// fire the pending note-off first
								if (rel_pend_q) begin
									rel_q <= rel_dec;
									if (rel_dec == '0) begin
										rel_pend_q <= 1'b0;
										if (snd_v_q) begin
											wk_off_v_q    <= 1'b1;
											wk_off_note_q <= snd_note_q;
											snd_v_q       <= 1'b0;
										end
									end
								end
								state_q <= ST_DIV;
							end
							sss_pkg::OP_TOGGLE: begin
								if (playing_q) begin
									playing_q    <= 1'b0;
									start_wait_q <= 1'b0;
									if (snd_v_q) begin
										wk_off_v_q    <= 1'b1;
										wk_off_note_q <= snd_note_q;
										snd_v_q       <= 1'b0;
									end
									state_q <= ST_DONE;
								end else begin
									pos_q        <= '0;
									mss_q        <= '0;
									start_wait_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (start_wait_q) begin
							playing_q    <= 1'b1;
							start_wait_q <= 1'b0;
							pos_q        <= '0;
							mss_q        <= '0;
							state_q      <= ST_PLAY1;
						end else if (playing_q) begin
							state_q <= ST_MUL1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL1: begin
					prod_q  <= sss_pkg::PROD_W'(half_ms) * sss_pkg::PROD_W'(swing_q);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					// divide by 50 through the reciprocal
					scaled_q <= sss_pkg::SCALED_W'(prod_q)
					          * sss_pkg::SCALED_W'(sss_pkg::RECIP_50);
					state_q  <= ST_STEP;
				end
				ST_STEP: begin
					if (mss_inc >= dur) begin
						mss_q   <= '0;
						pos_q   <= pos_wrap;
						state_q <= ST_PLAY1;
					end else begin
						mss_q   <= mss_inc;
						state_q <= ST_DONE;
					end
				end
				ST_PLAY1: begin
					// step beyond the pattern length plays nothing
					if (LW'(pos_q) >= len_rd_q)
						state_q <= ST_DONE;
					else
						state_q <= ST_PLAY2;
				end
				ST_PLAY2: begin
					if (snd_v_q) begin
						wk_off_v_q    <= 1'b1;
						wk_off_note_q <= snd_note_q;
					end
					snd_v_q <= step_rd_q.gate;
					if (step_rd_q.gate) begin
						wk_on_v_q    <= 1'b1;
						wk_on_note_q <= step_rd_q.note;
						wk_on_vel_q  <= step_rd_q.vel;
						snd_note_q   <= step_rd_q.note;
						rel_pend_q   <= 1'b1;
						rel_q        <= quotient[sss_pkg::QW-1:2];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the buffer has drained
					if (!out_valid)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output buffer: note-off beat first, then note-on
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_off_v_q <= 1'b0;
			ob_on_v_q  <= 1'b0;
		end else if ((state_q == ST_DONE) && !out_valid) begin
			ob_off_v_q <= wk_off_v_q;
			ob_on_v_q  <= wk_on_v_q;
		end else if (out_fire) begin
			if (ob_off_v_q)
				ob_off_v_q <= 1'b0;
			else
				ob_on_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && !out_valid) begin
			ob_off_status_q <= sss_pkg::STATUS_OFF | sss_pkg::STATUS_W'(chan_q);
			ob_on_status_q  <= sss_pkg::STATUS_ON | sss_pkg::STATUS_W'(chan_q);
			ob_off_note_q   <= wk_off_note_q;
			ob_on_note_q    <= wk_on_note_q;
			ob_on_vel_q     <= wk_on_vel_q;
			ob_step_q       <= sss_pkg::STEP_NOW_W'(pos_q);
		end
	end

	assign out_valid    = ob_off_v_q | ob_on_v_q;
	assign status_byte  = ob_off_v_q ? ob_off_status_q : ob_on_status_q;
	assign note_number  = ob_off_v_q ? ob_off_note_q : ob_on_note_q;
	assign velocity_out = ob_off_v_q ? '0 : ob_on_vel_q;
	assign step_now     = ob_step_q;
	assign last_of_run  = !(ob_off_v_q && ob_on_v_q);

endmodule

>>> rtl/sss_divider.sv
// ----------------------------------------------------------------------------
// sss_divider
// Restoring divider, one quotient bit per cycle: 16-bit dividend by an
// 8-bit nonzero divisor.
// ----------------------------------------------------------------------------
module sss_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sss_pkg::QW-1:0]       dividend,
	input  logic [sss_pkg::BPM_W-1:0]    divisor,
	output logic [sss_pkg::QW-1:0]       quotient,
	output sss_pkg::div_stat_t           stat
);

	localparam int CW = $clog2(sss_pkg::QW);

	logic [sss_pkg::QW-1:0]    quo_q;
	logic [sss_pkg::BPM_W-1:0] rem_q;
	logic [sss_pkg::BPM_W-1:0] dvs_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [sss_pkg::BPM_W:0]   trial;
	logic                      fits;
	logic [sss_pkg::BPM_W:0]   rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[sss_pkg::QW-1]};
		fits     = (trial >= {1'b0, dvs_q});
		rem_next = fits ? (trial - {1'b0, dvs_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(sss_pkg::QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[sss_pkg::QW-2:0], fits};
			rem_q <= rem_next[sss_pkg::BPM_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> rtl/sss_checker.sv
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks on the message stream of the step sequencer.
// ----------------------------------------------------------------------------
`include "swing_step_sequencer_core_defines.svh"

module sss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [sss_pkg::STATUS_W-1:0]    status_byte,
	input logic [sss_pkg::NOTE_W-1:0]      note_number,
	input logic [sss_pkg::VEL_W-1:0]       velocity_out,
	input logic                            last_of_run
);

	// a stalled beat holds
	`SSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status_byte) && $stable(note_number), "out beat changed while stalled")

	// only note-off and note-on messages
	`SSS_ASSERT_NOW(a_status_kind, out_valid, status_byte[7:5] == 3'b100, "status byte is not a note message")

	// note-off carries zero velocity
	`SSS_ASSERT_NOW(a_off_vel, out_valid && !status_byte[4], velocity_out == '0, "note-off with nonzero velocity")

	// the release always comes ahead of the new note
	`SSS_ASSERT_NOW(a_off_first, out_valid && !last_of_run, !status_byte[4], "non-final beat is not a note-off")

	// the rest of a run is ready at once
	`SSS_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !last_of_run, out_valid, "run broken after non-final beat")

endmodule

bind swing_step_sequencer_core sss_checker u_sss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status_byte  (status_byte),
	.note_number  (note_number),
	.velocity_out (velocity_out),
	.last_of_run  (last_of_run)
);

>>> sim/tb_swing_step_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_swing_step_sequencer_core
// Self-checking bench for the swing step sequencer. Drives ticks, play/stop
// toggles and step/length writes through the item channel and sets the four
// registers between phases. An item-level model of the sequencer predicts
// every note message, and each message beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_swing_step_sequencer_core;
	import sss_pkg::*;

	localparam int STEPS     = 8;
	localparam int PATTERNS  = 8;
	localparam int CYCLE_CAP = 1000000;
	localparam int ITEM_GOAL = 550;

	typedef struct {
		logic [1:0] op;
		logic [2:0] pslot;
		logic [2:0] sslot;
		logic [6:0] note;
		logic [6:0] vel;
		logic       gate;
		logic [3:0] len;
	} seq_cmd_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] note;
		logic [6:0] vel;
		logic [2:0] step;
		logic       last;
	} midi_msg_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            op = OP_TICK;
	logic [SLOT_W-1:0]     pattern_slot = '0;
	logic [SLOT_W-1:0]     step_slot = '0;
	logic [NOTE_W-1:0]     note_value = '0;
	logic [VEL_W-1:0]      velocity_value = '0;
	logic                  gate_on = 1'b0;
	logic [LEN_IN_W-1:0]   length_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status_byte;
	logic [NOTE_W-1:0]     note_number;
	logic [VEL_W-1:0]      velocity_out;
	logic [STEP_NOW_W-1:0] step_now;
	logic                  last_of_run;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEMPO;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// sequencer model state
	logic [6:0]  tab_note [PATTERNS*STEPS];
	logic [6:0]  tab_vel  [PATTERNS*STEPS];
	logic        tab_gate [PATTERNS*STEPS];
	logic [3:0]  pat_len  [PATTERNS];
	bit          playing, start_armed, rel_armed;
	int unsigned pos;
	logic [15:0] since_step, rel_left;
	logic [7:0]  held_note;
	logic [7:0]  cfg_bpm;
	logic [6:0]  cfg_swing;
	logic [3:0]  cfg_chan;
	logic [2:0]  cfg_psel;

	midi_msg_t item_msgs[$];
	midi_msg_t expected_msgs[$];

	int  fail_count = 0;
	int  cycle_count = 0;
	int  n_sent = 0, n_ticks = 0, n_toggles = 0, n_writes = 0;
	int  n_msgs = 0, n_phases = 0;
	bit  offering = 1'b0;
	bit  gaps_on = 1'b1;
	int  burst_left = 0;
	int  hold_req = 0, hold_left = 0, rx_mode = 0, mode_left = 0, rx_phase = 0;

	swing_step_sequencer_core #(
		.STEP_COUNT   (STEPS),
		.PATTERN_COUNT(PATTERNS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.pattern_slot  (pattern_slot),
		.step_slot     (step_slot),
		.note_value    (note_value),
		.velocity_value(velocity_value),
		.gate_on       (gate_on),
		.length_value  (length_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status_byte   (status_byte),
		.note_number   (note_number),
		.velocity_out  (velocity_out),
		.step_now      (step_now),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the sequencer
	// ------------------------------------------------------------------
	function automatic void reset_sequencer_model();
		for (int p = 0; p < PATTERNS; p++) begin
			pat_len[p] = 4'(STEPS);
			for (int s = 0; s < STEPS; s++) begin
				tab_note[p*STEPS+s] = 7'(NOTE_BASE + s);
				tab_vel[p*STEPS+s]  = VEL_DEFAULT;
				tab_gate[p*STEPS+s] = 1'b1;
			end
		end
		playing     = 1'b0;
		start_armed = 1'b0;
		rel_armed   = 1'b0;
		pos         = 0;
		since_step  = '0;
		rel_left    = '0;
		held_note   = 8'hFF;
		cfg_bpm     = BPM_RESET;
		cfg_swing   = SWING_RESET;
		cfg_chan    = '0;
		cfg_psel    = '0;
	endfunction

	function automatic int unsigned beat_ms();
		int unsigned b;
		b = cfg_bpm;
		if (b == 0)
			b = 1;
		return 60000 / b;
	endfunction

	function automatic void emit_msg(logic [7:0] st, logic [6:0] nt, logic [6:0] vl);
		midi_msg_t m;
		m = '0;
		m.status = st;
		m.note   = nt;
		m.vel    = vl;
		if (item_msgs.size() < 2)
			item_msgs.push_back(m);
	endfunction

	function automatic void release_held();
		if (held_note < 128) begin
			emit_msg(STATUS_OFF | {4'h0, cfg_chan}, held_note[6:0], '0);
			held_note = 8'hFF;
		end
	endfunction

	function automatic void sound_step();
		int unsigned p, idx;
		p = cfg_psel % PATTERNS;
		if (pos >= pat_len[p] || pos >= STEPS)
			return;
		idx = p * STEPS + pos;
		release_held();
		if (tab_gate[idx]) begin
			emit_msg(STATUS_ON | {4'h0, cfg_chan}, tab_note[idx], tab_vel[idx]);
			held_note = {1'b0, tab_note[idx]};
			rel_armed = 1'b1;
			rel_left  = 16'(beat_ms() / 4);
		end
	endfunction

	function automatic void model_tick();
		int unsigned dur;
		if (rel_armed) begin
			if (rel_left > 0)
				rel_left--;
			if (rel_left == 0) begin
				release_held();
				rel_armed = 1'b0;
			end
		end
		if (start_armed) begin
			playing     = 1'b1;
			start_armed = 1'b0;
			pos         = 0;
			since_step  = '0;
			sound_step();
			return;
		end
		if (playing) begin
			dur = beat_ms() / 2;
			// odd steps carry the swing
			if (pos[0])
				dur = dur * cfg_swing / 50;
			if (dur > 65535)
				dur = 65535;
			if (since_step < 16'hFFFF)
				since_step++;
			if (since_step >= dur) begin
				since_step = '0;
				pos++;
				if (pos >= pat_len[cfg_psel % PATTERNS])
					pos = 0;
				sound_step();
			end
		end
	endfunction

	function automatic void model_cmd(seq_cmd_t c);
		int unsigned idx, ln;
		item_msgs.delete();
		case (c.op)
			OP_TICK: begin
				model_tick();
			end
			OP_TOGGLE: begin
				if (playing) begin
					playing     = 1'b0;
					start_armed = 1'b0;
					release_held();
				end else begin
					pos         = 0;
					start_armed = 1'b1;
					since_step  = '0;
				end
			end
			OP_STEP: begin
				if (c.pslot < PATTERNS && c.sslot < STEPS) begin
					idx = int'(c.pslot) * STEPS + int'(c.sslot);
					tab_note[idx] = c.note;
					tab_vel[idx]  = c.vel;
					tab_gate[idx] = c.gate;
				end
			end
			default: begin
				if (c.pslot < PATTERNS) begin
					ln = c.len;
					if (ln < 1)
						ln = 1;
					if (ln > STEPS)
						ln = STEPS;
					pat_len[c.pslot] = 4'(ln);
				end
			end
		endcase
		foreach (item_msgs[k]) begin
			item_msgs[k].step = pos[2:0];
			item_msgs[k].last = (k == item_msgs.size() - 1);
			expected_msgs.push_back(item_msgs[k]);
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic seq_cmd_t noise_cmd(logic [1:0] code);
		seq_cmd_t c;
		c.op    = code;
		c.pslot = 3'($urandom_range(0, 7));
		c.sslot = 3'($urandom_range(0, 7));
		c.note  = 7'($urandom_range(0, 127));
		c.vel   = 7'($urandom_range(0, 127));
		c.gate  = 1'($urandom_range(0, 1));
		c.len   = 4'($urandom_range(0, 15));
		return c;
	endfunction

	function automatic seq_cmd_t step_cmd(logic [2:0] p, logic [2:0] s, logic [6:0] n,
			logic [6:0] v, logic g);
		seq_cmd_t c;
		c       = noise_cmd(OP_STEP);
		c.pslot = p;
		c.sslot = s;
		c.note  = n;
		c.vel   = v;
		c.gate  = g;
		return c;
	endfunction

	function automatic seq_cmd_t len_cmd(logic [2:0] p, logic [3:0] l);
		seq_cmd_t c;
		c       = noise_cmd(OP_LENGTH);
		c.pslot = p;
		c.len   = l;
		return c;
	endfunction

	// Offer one beat, hold it until taken, then maybe open a gap.
	task automatic issue_cmd(seq_cmd_t c);
		in_valid       <= 1'b1;
		op             <= c.op;
		pattern_slot   <= c.pslot;
		step_slot      <= c.sslot;
		note_value     <= c.note;
		velocity_value <= c.vel;
		gate_on        <= c.gate;
		length_value   <= c.len;
		offering = 1'b1;
		do @(posedge clk); while (!in_ready);
		model_cmd(c);
		n_sent++;
		case (c.op)
			OP_TICK:   n_ticks++;
			OP_TOGGLE: n_toggles++;
			default:   n_writes++;
		endcase
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				in_valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TEMPO:   cfg_bpm   = data;
			CFG_SWING:   cfg_swing = data[6:0];
			CFG_CHANNEL: cfg_chan  = data[3:0];
			default:     cfg_psel  = data[2:0];
		endcase
	endtask

	task automatic set_config(logic [7:0] t, logic [7:0] s, logic [7:0] ch, logic [7:0] ps);
		write_reg(CFG_TEMPO, t);
		write_reg(CFG_SWING, s);
		write_reg(CFG_CHANNEL, ch);
		write_reg(CFG_PATTERN, ps);
		cfg_valid <= 1'b0;
		n_phases++;
	endtask

	// Drop valid, drain all expected messages, then let a silent tick finish.
	task automatic settle();
		int waited;
		waited = 0;
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (expected_msgs.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (64) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_writes_and_start();
		issue_cmd(noise_cmd(OP_TICK));                  // idle tick, no output
		issue_cmd(len_cmd(3'd0, 4'd0));                 // zero length clamps to one
		issue_cmd(len_cmd(3'd7, 4'd15));                // oversize length clamps
		issue_cmd(len_cmd(3'd3, 4'd8));
		issue_cmd(step_cmd(3'd0, 3'd0, 7'd127, 7'd127, 1'b1));
		issue_cmd(step_cmd(3'd7, 3'd7, 7'd0, 7'd0, 1'b0));
		issue_cmd(noise_cmd(OP_TOGGLE));
		issue_cmd(noise_cmd(OP_TOGGLE));                // restart the pending start
		issue_cmd(noise_cmd(OP_TICK));                  // start, note-on
		issue_cmd(noise_cmd(OP_TICK));
		issue_cmd(noise_cmd(OP_TOGGLE));                // stop, note-off
		issue_cmd(noise_cmd(OP_TICK));                  // release stays armed, silent
	endtask

	task automatic test_extreme_config();
		settle();
		set_config(8'd0, 8'd127, 8'd15, 8'd7);
		issue_cmd(noise_cmd(OP_TOGGLE));
		issue_cmd(noise_cmd(OP_TICK));
		issue_cmd(noise_cmd(OP_TICK));
		issue_cmd(noise_cmd(OP_TOGGLE));
		issue_cmd(noise_cmd(OP_TICK));
		issue_cmd(step_cmd(3'd7, 3'd0, 7'd5, 7'd9, 1'b0));
		issue_cmd(noise_cmd(OP_TOGGLE));
		issue_cmd(noise_cmd(OP_TICK));                  // start on a silent step
		issue_cmd(noise_cmd(OP_TOGGLE));                // stop with nothing sounding
	endtask

	task automatic test_zero_swing_run();
		settle();
		set_config(8'd255, 8'd0, 8'($urandom_range(0, 15)), 8'd1);
		gaps_on = 1'b0;
		if (!playing && !start_armed)
			issue_cmd(noise_cmd(OP_TOGGLE));
		repeat (260) begin
			issue_cmd(noise_cmd(OP_TICK));
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		settle();
		issue_cmd(step_cmd(cfg_psel, 3'd0, 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 1'b1));
		// receiver holds off while toggles and ticks keep coming
		hold_req = 400;
		repeat (16) begin
			issue_cmd(noise_cmd(OP_TOGGLE));
			issue_cmd(noise_cmd(OP_TICK));
		end
	endtask

	task automatic test_random_phases();
		int n_items, r;
		seq_cmd_t c;
		logic [7:0] t, s;
		while (n_sent < ITEM_GOAL) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 6)
				t = 8'($urandom_range(200, 255));
			else if (r < 8)
				t = 8'($urandom_range(0, 255));
			else if (r == 8)
				t = 8'd240;
			else
				t = 8'd40;
			case ($urandom_range(0, 5))
				0:       s = 8'd0;
				1:       s = 8'd50;
				2:       s = 8'd100;
				3:       s = 8'd127;
				default: s = 8'($urandom_range(0, 255));
			endcase
			set_config(t, s, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			gaps_on = ($urandom_range(0, 3) != 0);
			if (!playing && !start_armed)
				issue_cmd(noise_cmd(OP_TOGGLE));
			n_items = $urandom_range(40, 120);
			if (n_items > ITEM_GOAL - n_sent)
				n_items = ITEM_GOAL - n_sent;
			repeat (n_items) begin
				r = $urandom_range(0, 99);
				if (r < 84) begin
					c = noise_cmd(OP_TICK);
				end else if (r < 89) begin
					c = noise_cmd(OP_TOGGLE);
				end else if (r < 95) begin
					c = noise_cmd(OP_STEP);
					c.gate = ($urandom_range(0, 3) != 0);
				end else begin
					c = noise_cmd(OP_LENGTH);
					if ($urandom_range(0, 4) != 0)
						c.len = 4'($urandom_range(1, 8));
				end
				issue_cmd(c);
			end
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// receiver pacing
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (mode_left <= 0) begin
				rx_mode   = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			rx_phase++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					2:       out_ready <= (rx_phase % 3 != 0);
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// message checker
	// ------------------------------------------------------------------
	task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : msg_check
		midi_msg_t want;
		if (arst_n && out_valid && out_ready) begin
			n_msgs++;
			if (expected_msgs.size() == 0) begin
				$error("unexpected message beat: status %0h note %0d vel %0d",
					status_byte, note_number, velocity_out);
				fail_count++;
			end else begin
				want = expected_msgs.pop_front();
				check_field("status_byte", want.status, status_byte);
				check_field("note_number", 8'(want.note), 8'(note_number));
				check_field("velocity_out", 8'(want.vel), 8'(velocity_out));
				check_field("step_now", 8'(want.step), 8'(step_now));
				check_field("last_of_run", 8'(want.last), 8'(last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("Timeout after %0d cycles, %0d messages still expected",
				cycle_count, expected_msgs.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		reset_sequencer_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_writes_and_start();
		test_extreme_config();
		test_zero_swing_run();
		test_backpressure();
		test_random_phases();
		settle();
		if (expected_msgs.size() > 0) begin
			$error("%0d expected messages never arrived", expected_msgs.size());
			fail_count += expected_msgs.size();
		end
		$display("Run covered %0d items: %0d ticks, %0d play/stop toggles, %0d table writes",
			n_sent, n_ticks, n_toggles, n_writes);
		$display("%0d register phases incl. tempo 0 and 255, %0d note messages checked",
			n_phases, n_msgs);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
